// File: hdl/hmp_pkg.sv
// Shared types, constants and helpers for the hash message padder.
`timescale 1ns / 1ps

package hmp_pkg;

    localparam int LENGTH_FIELD_BYTES = 8;
    localparam int WORD_BYTES         = 8;
    localparam int CMD_FIFO_DEPTH     = 4;
    localparam int CMD_PTR_W          = $clog2(CMD_FIFO_DEPTH);

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE_LOG2   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_BIG_ENDIAN = 1'd1;

    localparam logic [2:0] BLOCK_LOG2_MIN   = 3'd4;
    localparam logic [2:0] BLOCK_LOG2_RESET = 3'd6;
    localparam logic [7:0] PAD_MARKER       = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] out_word;
        logic        block_end;
        logic        message_end;
    } t_out_beat;

    // One queue entry: an optional finished data word, then an optional pad run.
    typedef struct packed {
        logic        has_word;
        logic        is_pad;
        logic [63:0] word;
        logic        block_end;
        logic [63:0] pad_word;
        logic [3:0]  word_idx;
        logic [63:0] len_word;
    } t_cmd;

    // Byte position mask within a block, block size clamped to 16 bytes minimum.
    function automatic logic [6:0] blk_mask(input logic [2:0] lg);
        logic [2:0] lg_eff;
        logic [7:0] m8;
        lg_eff = (lg < BLOCK_LOG2_MIN) ? BLOCK_LOG2_MIN : lg;
        m8     = (8'd1 << lg_eff) - 8'd1;
        return m8[6:0];
    endfunction

    function automatic logic [63:0] byte_swap64(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < WORD_BYTES; i++) begin
            r[8*i +: 8] = v[8*(WORD_BYTES-1-i) +: 8];
        end
        return r;
    endfunction

endpackage

// File: hdl/hmp_front.sv
// Front end: takes byte beats, packs words, builds pad commands.
`timescale 1ns / 1ps

module hmp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hmp_pkg::t_in_beat i_in,
    input  logic [6:0]        i_mask,
    input  logic              i_big_endian,
    input  logic              i_cmd_full,
    output logic              o_cmd_push,
    output hmp_pkg::t_cmd     o_cmd
);
    import hmp_pkg::*;

    logic [60:0] r_cnt;
    logic [55:0] r_part;
    logic [2:0]  r_biw;

    logic        w_accept;
    logic [60:0] w_cnt1;
    logic [6:0]  w_pos;
    logic        w_full;
    logic [55:0] w_part1;
    logic [2:0]  w_biw1;
    logic [63:0] w_bits;
    logic [5:0]  w_shift;

    assign o_in_ready = !i_cmd_full;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_cnt1  = i_in.byte_present ? (r_cnt + 61'd1) : r_cnt;
    assign w_pos   = w_cnt1[6:0] & i_mask;
    assign w_full  = i_in.byte_present && (r_biw == 3'd7);
    assign w_part1 = !i_in.byte_present ? r_part :
                     w_full ? 56'd0 : {r_part[47:0], i_in.data_byte};
    assign w_biw1  = i_in.byte_present ? (r_biw + 3'd1) : r_biw;
    assign w_bits  = {w_cnt1, 3'b000};
    assign w_shift = {3'd7 - w_biw1, 3'b000};

    always_comb begin
        o_cmd.has_word  = w_full;
        o_cmd.is_pad    = i_in.end_of_message;
        o_cmd.word      = {r_part, i_in.data_byte};
        o_cmd.block_end = (w_pos == 7'd0);
        o_cmd.pad_word  = {w_part1, PAD_MARKER} << w_shift;
        o_cmd.word_idx  = w_pos[6:3];
        o_cmd.len_word  = i_big_endian ? w_bits : byte_swap64(w_bits);
    end

    assign o_cmd_push = w_accept && (w_full || i_in.end_of_message);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_part <= '0;
            r_biw  <= '0;
        end else if (w_accept) begin
            if (i_in.end_of_message) begin
                r_cnt  <= '0;
                r_part <= '0;
                r_biw  <= '0;
            end else begin
                r_cnt  <= w_cnt1;
                r_part <= w_part1;
                r_biw  <= w_biw1;
            end
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.end_of_message) |=> (r_cnt == 61'd0 && r_biw == 3'd0))
        else $error("message state not cleared after end beat");

endmodule

// File: hdl/hmp_fifo.sv
// Short command queue between front and back.
`timescale 1ns / 1ps

module hmp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hmp_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_not_empty,
    output hmp_pkg::t_cmd o_cmd
);
    import hmp_pkg::*;

    t_cmd                 r_mem [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr;
    logic [CMD_PTR_W-1:0] r_rd;
    logic [CMD_PTR_W:0]   r_cnt;

    assign o_full      = (r_cnt == (CMD_PTR_W+1)'(CMD_FIFO_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + CMD_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + CMD_PTR_W'(1);
            end
            r_cnt <= r_cnt + (CMD_PTR_W+1)'(i_push) - (CMD_PTR_W+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_not_empty))
        else $error("command queue underflow");

endmodule

// File: hdl/hmp_back.sv
// Back end: drains commands and sends data and padding words.
`timescale 1ns / 1ps

module hmp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    input  hmp_pkg::t_cmd      i_cmd,
    input  logic [3:0]         i_last_idx,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hmp_pkg::t_out_beat o_out
);
    import hmp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_ZERO,
        S_LEN
    } t_state;

    t_state     r_state;
    t_cmd       r_cmd;
    logic [3:0] r_idx;
    logic       r_out_valid;
    t_out_beat  r_out;

    logic       w_load;
    logic       w_emit;
    logic [3:0] w_pad_nx;
    logic [3:0] w_zero_nx;

    assign w_load    = !r_out_valid || i_out_ready;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid && w_load;
    assign w_emit    = (r_state == S_IDLE) ? (o_cmd_pop && i_cmd.has_word) : w_load;
    assign w_pad_nx  = (r_cmd.word_idx == i_last_idx) ? 4'd0 : (r_cmd.word_idx + 4'd1);
    assign w_zero_nx = r_idx + 4'd1;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.has_word) begin
                            r_out.out_word    <= i_cmd.word;
                            r_out.block_end   <= i_cmd.block_end;
                            r_out.message_end <= 1'b0;
                        end
                        if (i_cmd.is_pad) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (w_load) begin
                        r_out.out_word    <= r_cmd.pad_word;
                        r_out.block_end   <= (r_cmd.word_idx == i_last_idx);
                        r_out.message_end <= 1'b0;
                        r_idx             <= w_pad_nx;
                        r_state           <= (w_pad_nx == i_last_idx) ? S_LEN : S_ZERO;
                    end
                end
                S_ZERO: begin
                    if (w_load) begin
                        r_out.out_word    <= '0;
                        r_out.block_end   <= 1'b0;
                        r_out.message_end <= 1'b0;
                        r_idx             <= w_zero_nx;
                        if (w_zero_nx == i_last_idx) begin
                            r_state <= S_LEN;
                        end
                    end
                end
                S_LEN: begin
                    if (w_load) begin
                        r_out.out_word    <= r_cmd.len_word;
                        r_out.block_end   <= 1'b1;
                        r_out.message_end <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_msg_end_on_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.message_end) |-> r_out.block_end)
        else $error("message end word not on a block boundary");

    a_len_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN && w_load) |=> (r_state == S_IDLE && r_out.message_end))
        else $error("length word did not close the pad run");

endmodule

// File: hdl/hash_message_padder_unit.sv
// Top level of the Merkle-Damgard length padder.
`timescale 1ns / 1ps

// Message bytes enter one beat per cycle while the four-entry command queue has
// room; a beat that completes a word, or ends the message, takes a queue entry.
// The back end sends one word per cycle unless stalled: a data word is registered
// when its entry is popped and goes out in the cycle after, and an end-of-message
// entry emits its pad run of 2 to 17 words (0x80 word, zero words, length word)
// one per cycle once loaded. That pad run sets the sustained rate at message ends;
// the front keeps taking bytes during it until the queue fills. Configuration
// writes are taken at any cycle and must only occur while the block is idle.
module hash_message_padder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  hmp_pkg::t_in_beat                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output hmp_pkg::t_out_beat                  o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hmp_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [hmp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import hmp_pkg::*;

    logic [2:0] r_block_lg;
    logic       r_big_endian;
    logic [6:0] w_mask;

    logic       w_push;
    t_cmd       w_push_cmd;
    logic       w_full;
    logic       w_pop;
    logic       w_not_empty;
    t_cmd       w_head_cmd;

    assign o_cfg_ready = 1'b1;
    assign w_mask      = blk_mask(r_block_lg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_lg   <= BLOCK_LOG2_RESET;
            r_big_endian <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BLOCK_SIZE_LOG2:   r_block_lg   <= i_cfg_data[2:0];
                CFG_LENGTH_BIG_ENDIAN: r_big_endian <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    hmp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_mask       (w_mask),
        .i_big_endian (r_big_endian),
        .i_cmd_full   (w_full),
        .o_cmd_push   (w_push),
        .o_cmd        (w_push_cmd)
    );

    hmp_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_cmd       (w_push_cmd),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_cmd       (w_head_cmd)
    );

    hmp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_not_empty),
        .o_cmd_pop   (w_pop),
        .i_cmd       (w_head_cmd),
        .i_last_idx  (w_mask[6:3]),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// File: tb/testbench.sv
// Testbench for hash_message_padder_unit: random beats checked against a padding predictor.
`timescale 1ns / 1ps

class pad_tracker;
    hmp_pkg::t_out_beat pending_words[$];
    int unsigned        n_errors;
    logic [2:0]         blk_log2;
    logic               len_big_endian;
    logic [60:0]        msg_bytes;
    logic [55:0]        held_bytes;
    logic [2:0]         held_count;

    function new();
        n_errors       = 0;
        blk_log2       = hmp_pkg::BLOCK_LOG2_RESET;
        len_big_endian = 1'b1;
        clear_message();
    endfunction

    function void clear_message();
        msg_bytes  = '0;
        held_bytes = '0;
        held_count = '0;
    endfunction

    function void note_setting(logic [hmp_pkg::CFG_INDEX_W-1:0] idx,
                               logic [hmp_pkg::CFG_DATA_W-1:0] val);
        if (idx == hmp_pkg::CFG_BLOCK_SIZE_LOG2) begin
            blk_log2 = val;
        end else if (idx == hmp_pkg::CFG_LENGTH_BIG_ENDIAN) begin
            len_big_endian = val[0];
        end
    endfunction

    // pos is the block position just past this byte
    function void append_byte(logic [7:0] b, int pos);
        hmp_pkg::t_out_beat w;
        if (held_count == 3'd7) begin
            w.out_word    = {held_bytes, b};
            w.block_end   = (pos == 0);
            w.message_end = 1'b0;
            pending_words.push_back(w);
            held_bytes = '0;
            held_count = '0;
        end else begin
            held_bytes = {held_bytes[47:0], b};
            held_count++;
        end
    endfunction

    function void absorb_beat(hmp_pkg::t_in_beat b);
        int                 mask;
        int                 pos;
        int                 target;
        logic [63:0]        bit_len;
        hmp_pkg::t_out_beat last;
        mask = (1 << ((blk_log2 < hmp_pkg::BLOCK_LOG2_MIN) ? int'(hmp_pkg::BLOCK_LOG2_MIN)
                                                            : int'(blk_log2))) - 1;
        if (b.byte_present) begin
            msg_bytes++;
            append_byte(b.data_byte, int'(msg_bytes[6:0]) & mask);
        end
        if (b.end_of_message) begin
            bit_len = {msg_bytes, 3'b000};
            target  = mask + 1 - hmp_pkg::LENGTH_FIELD_BYTES;
            pos     = (int'(msg_bytes[6:0]) + 1) & mask;
            append_byte(hmp_pkg::PAD_MARKER, pos);
            while (pos != target) begin
                pos = (pos + 1) & mask;
                append_byte(8'h00, pos);
            end
            for (int i = 0; i < hmp_pkg::LENGTH_FIELD_BYTES; i++) begin
                pos = (pos + 1) & mask;
                append_byte(len_big_endian ? bit_len[63-8*i -: 8] : bit_len[8*i +: 8], pos);
            end
            last = pending_words.pop_back();
            last.message_end = 1'b1;
            pending_words.push_back(last);
            clear_message();
        end
    endfunction

    function void match_word(hmp_pkg::t_out_beat got);
        hmp_pkg::t_out_beat want;
        if (pending_words.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected beat, expected none, actual word %h block_end %b message_end %b",
                     $time, got.out_word, got.block_end, got.message_end);
            return;
        end
        want = pending_words.pop_front();
        if (got.out_word !== want.out_word) begin
            n_errors++;
            $display("%0t: out_word expected %h actual %h", $time, want.out_word, got.out_word);
        end
        if (got.block_end !== want.block_end) begin
            n_errors++;
            $display("%0t: block_end expected %b actual %b", $time, want.block_end, got.block_end);
        end
        if (got.message_end !== want.message_end) begin
            n_errors++;
            $display("%0t: message_end expected %b actual %b",
                     $time, want.message_end, got.message_end);
        end
    endfunction
endclass

module testbench;
    import hmp_pkg::*;

    localparam int SETTLE_CYCLES = 48;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 35;

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_CHOKED} t_rx_mode;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    t_in_beat               i_in        = '0;
    logic                   i_out_ready = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    t_out_beat              o_out;
    logic                   o_cfg_ready;

    pad_tracker board = new();
    int         burst_left = 0;
    int         items_sent = 0;
    t_rx_mode   rx_mode    = RX_FREE;
    int         rx_left    = 0;

    hash_message_padder_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                board.note_setting(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                board.absorb_beat(i_in);
            end
            if (o_out_valid && i_out_ready) begin
                board.match_word(o_out);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_left <= $urandom_range(4, 60);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE: begin
                i_out_ready <= 1'b1;
            end
            RX_RANDOM: begin
                i_out_ready <= $urandom_range(0, 1);
            end
            default: begin
                i_out_ready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    task automatic send_item(input t_in_beat b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 96)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        i_in       <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_message(input int len, input logic empty_end);
        t_in_beat b;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                b = '{data_byte: 8'($urandom), byte_present: 1'b0, end_of_message: 1'b0};
                send_item(b);
            end
            b = '{data_byte: 8'($urandom), byte_present: 1'b1,
                  end_of_message: (i == len - 1) && !empty_end};
            send_item(b);
            items_sent++;
        end
        if (empty_end || len == 0) begin
            b = '{data_byte: 8'($urandom), byte_present: 1'b0, end_of_message: 1'b1};
            send_item(b);
            items_sent++;
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (board.pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [2:0] lg, input logic be);
        i_cfg_index <= CFG_BLOCK_SIZE_LOG2;
        i_cfg_data  <= lg;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_LENGTH_BIG_ENDIAN;
        i_cfg_data  <= {2'b00, be};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [2:0] lg_plan [4];
        logic       be_plan [4];
        logic [2:0] lg;
        int         blk;
        int         limit;

        lg_plan = '{3'd4, 3'd7, 3'd0, 3'd7};
        be_plan = '{1'b0, 1'b1, 1'b1, 1'b0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty message, idle beat, one-byte messages
        send_item('{data_byte: 8'h5A, byte_present: 1'b0, end_of_message: 1'b1});
        send_item('{data_byte: 8'hA5, byte_present: 1'b0, end_of_message: 1'b0});
        send_item('{data_byte: 8'hFF, byte_present: 1'b1, end_of_message: 1'b1});
        send_item('{data_byte: 8'h00, byte_present: 1'b1, end_of_message: 1'b0});
        send_item('{data_byte: 8'h3C, byte_present: 1'b0, end_of_message: 1'b0});
        send_item('{data_byte: 8'hC3, byte_present: 1'b0, end_of_message: 1'b1});
        settle();

        // below-minimum block size, little-endian; 8 bytes spills into a second block
        load_settings(3'd0, 1'b0);
        send_message(8, 1'b0);
        send_message(7, 1'b0);
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 4) begin
                load_settings(lg_plan[ph], be_plan[ph]);
                lg = lg_plan[ph];
            end else begin
                lg = 3'($urandom_range(0, 7));
                load_settings(lg, 1'($urandom_range(0, 1)));
            end
            blk   = 1 << ((lg < BLOCK_LOG2_MIN) ? int'(BLOCK_LOG2_MIN) : int'(lg));
            limit = items_sent + PHASE_ITEMS;
            while (items_sent < limit) begin
                send_message($urandom_range(0, blk + 12), ($urandom_range(0, 1) == 1));
            end
            settle();
        end

        if (board.n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("status: fail");
        $finish;
    end
endmodule
